/* hdl/page_framebuffer_glyph_writer_assert.svh */
// Assertion helpers for the glyph writer checker
`ifndef PAGE_FRAMEBUFFER_GLYPH_WRITER_ASSERT_SVH
`define PAGE_FRAMEBUFFER_GLYPH_WRITER_ASSERT_SVH

// same-cycle implication
`define PFGW_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pfgw check failed");

// next-cycle implication
`define PFGW_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pfgw check failed");

`endif

/* hdl/pfgw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package pfgw_pkg;

	localparam int DISP_COLS   = 128;
	localparam int DISP_ROWS   = 64;
	localparam int PAGES       = DISP_ROWS / 8;
	localparam int STORE_BYTES = DISP_COLS * DISP_ROWS / 8;
	localparam int ADDR_W      = $clog2(STORE_BYTES);

	localparam logic [7:0] WIDTH_LIM  = 8'(DISP_COLS);
	localparam logic [7:0] HEIGHT_LIM = 8'(DISP_ROWS);
	localparam logic [7:0] PAGE_LIM   = 8'(PAGES);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

	// request queues; depth must be a power of two
	localparam int Q_DEPTH = 2;
	localparam int QPTR_W  = $clog2(Q_DEPTH);
	localparam int QCNT_W  = QPTR_W + 1;

	typedef enum logic [2:0] {
		ACT_CURSOR = 3'd0,
		ACT_FILL   = 3'd1,
		ACT_PIXEL  = 3'd2,
		ACT_GLYPH  = 3'd3,
		ACT_READ   = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_RANGE  = 2'd1,
		STAT_BADCOL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		K_NONE = 2'd0,
		K_FILL = 2'd1,
		K_RMW  = 2'd2,
		K_READ = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		status_t           status;
		logic [ADDR_W-1:0] addr;
		logic [4:0]        count;
		logic [15:0]       pattern;
		logic [2:0]        bit_idx;
		logic              fill;
	} cmd_t;

	typedef struct packed {
		status_t    status;
		logic [7:0] data;
	} res_t;

	typedef struct packed {
		logic pop;
		logic clearing;
	} back_ctl_t;

	function automatic logic [ADDR_W-1:0] byte_addr(input logic [6:0] x,
			input logic [3:0] page);
		return ADDR_W'(x) + ADDR_W'(page) * ADDR_W'(DISP_COLS);
	endfunction

endpackage
`default_nettype wire

/* hdl/pfgw_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module pfgw_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [2:0]         action,
	input  logic [6:0]         pos_x,
	input  logic [6:0]         pos_y,
	input  logic               pixel_value,
	input  logic [15:0]        glyph_pattern,
	input  logic [4:0]         glyph_row,
	input  logic [4:0]         start_col,
	input  logic [4:0]         glyph_width,
	input  logic               last_row,
	output logic               cmd_valid,
	output pfgw_pkg::cmd_t     cmd_head,
	input  pfgw_pkg::back_ctl_t back_ctl
);
	import pfgw_pkg::*;

	logic [6:0] cursor_x_q;
	logic [6:0] cursor_y_q;

	cmd_t              cmd_mem_q [Q_DEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] cnt_q;

	logic       accept;
	logic [7:0] row_y;
	logic [4:0] span;
	logic [7:0] room;
	logic [4:0] ncols;
	logic       set_cur;
	logic       adv_cur;
	cmd_t       cmd_new;

	assign accept    = push && !full;
	assign full      = (cnt_q == QCNT_W'(Q_DEPTH)) || back_ctl.clearing;
	assign cmd_valid = (cnt_q != '0);
	assign cmd_head  = cmd_mem_q[rptr_q];

	// columns left before the right edge stops the row
	assign row_y = 8'(cursor_y_q) + 8'(glyph_row);
	assign span  = glyph_width - start_col;
	assign room  = ({1'b0, cursor_x_q} + 8'd1 >= WIDTH_LIM) ? 8'd0 :
		WIDTH_LIM - 8'd1 - {1'b0, cursor_x_q};
	assign ncols = ({3'b000, span} < room) ? span : room[4:0];

	always_comb begin
		cmd_new        = '0;
		cmd_new.kind   = K_NONE;
		cmd_new.status = STAT_OK;
		set_cur        = 1'b0;
		adv_cur        = 1'b0;
		unique case (action)
			ACT_CURSOR: begin
				set_cur = 1'b1;
			end
			ACT_FILL: begin
				cmd_new.kind = K_FILL;
				cmd_new.fill = pixel_value;
			end
			ACT_PIXEL: begin
				if ({1'b0, pos_x} >= WIDTH_LIM || {1'b0, pos_y} >= HEIGHT_LIM) begin
					cmd_new.status = STAT_RANGE;
				end else begin
					cmd_new.kind    = K_RMW;
					cmd_new.addr    = byte_addr(pos_x, pos_y[6:3]);
					cmd_new.count   = 5'd1;
					cmd_new.pattern = {pixel_value, 15'd0};
					cmd_new.bit_idx = pos_y[2:0];
				end
			end
			ACT_GLYPH: begin
				if (start_col > glyph_width) begin
					cmd_new.status = STAT_BADCOL;
				end else if (row_y >= HEIGHT_LIM) begin
					cmd_new.status = STAT_RANGE;
				end else begin
					adv_cur = last_row;
					if (ncols != 5'd0) begin
						cmd_new.kind    = K_RMW;
						cmd_new.addr    = byte_addr(cursor_x_q, row_y[6:3]);
						cmd_new.count   = ncols;
						cmd_new.pattern = glyph_pattern << start_col;
						cmd_new.bit_idx = row_y[2:0];
					end
				end
			end
			ACT_READ: begin
				if ({1'b0, pos_x} >= WIDTH_LIM || {1'b0, pos_y} >= PAGE_LIM) begin
					cmd_new.status = STAT_RANGE;
				end else begin
					cmd_new.kind = K_READ;
					cmd_new.addr = byte_addr(pos_x, pos_y[3:0]);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q <= '0;
			cursor_y_q <= '0;
			wptr_q     <= '0;
			rptr_q     <= '0;
			cnt_q      <= '0;
		end else begin
			if (accept && set_cur) begin
				cursor_x_q <= pos_x;
				cursor_y_q <= pos_y;
			end else if (accept && adv_cur) begin
				cursor_x_q <= cursor_x_q + 7'(ncols);
			end
			if (accept) begin
				wptr_q <= wptr_q + QPTR_W'(1);
			end
			if (back_ctl.pop) begin
				rptr_q <= rptr_q + QPTR_W'(1);
			end
			case ({accept, back_ctl.pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_mem_q[wptr_q] <= cmd_new;
		end
	end

endmodule
`default_nettype wire

/* hdl/pfgw_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module pfgw_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	input  pfgw_pkg::cmd_t      cmd_head,
	output pfgw_pkg::back_ctl_t back_ctl,
	input  logic                pop,
	output logic                empty,
	output logic [1:0]          status,
	output logic [7:0]          read_data
);
	import pfgw_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SWEEP = 5'b00010,
		S_RMW   = 5'b00100,
		S_DRAIN = 5'b01000,
		S_READ  = 5'b10000
	} state_t;

	state_t            state_q;
	logic [ADDR_W-1:0] addr_q;
	logic              fill_q;
	logic              report_q;
	logic [4:0]        left_q;
	logic [15:0]       pat_q;
	logic [2:0]        bit_q;

	logic              wr_valid_s1;
	logic [ADDR_W-1:0] wr_addr_s1;
	logic              wr_on_s1;

	logic [7:0]        store_q [STORE_BYTES];
	logic [7:0]        rdata_q;

	res_t              res_mem_q [Q_DEPTH];
	logic [QPTR_W-1:0] res_wptr_q;
	logic [QPTR_W-1:0] res_rptr_q;
	logic [QCNT_W-1:0] res_cnt_q;

	logic              res_space;
	logic              start;
	logic              res_push;
	logic              res_pop;
	res_t              res_new;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [ADDR_W-1:0] mem_raddr;
	logic [7:0]        mem_wdata;
	logic [7:0]        bit_mask;

	assign res_space = (res_cnt_q != QCNT_W'(Q_DEPTH));
	// a request starts only with room for its result already reserved
	assign start     = (state_q == S_IDLE) && cmd_valid && res_space;
	assign res_pop   = pop && !empty;

	assign back_ctl.pop      = start;
	assign back_ctl.clearing = (state_q == S_SWEEP) && !report_q;

	always_comb begin
		res_push       = 1'b0;
		res_new.status = STAT_OK;
		res_new.data   = 8'd0;
		unique case (state_q)
			S_IDLE: begin
				if (start && cmd_head.kind == K_NONE) begin
					res_push       = 1'b1;
					res_new.status = cmd_head.status;
				end
			end
			S_SWEEP: res_push = (addr_q == LAST_ADDR) && report_q;
			S_RMW:   res_push = 1'b0;
			S_DRAIN: res_push = 1'b1;
			S_READ: begin
				res_push     = 1'b1;
				res_new.data = rdata_q;
			end
			default: res_push = 1'b0;
		endcase
	end

	// read-modify-write: read issued one cycle, write-back the next
	assign bit_mask  = 8'd1 << bit_q;
	assign mem_we    = (state_q == S_SWEEP) || wr_valid_s1;
	assign mem_waddr = (state_q == S_SWEEP) ? addr_q : wr_addr_s1;
	assign mem_wdata = (state_q == S_SWEEP) ? {8{fill_q}} :
		(wr_on_s1 ? (rdata_q | bit_mask) : (rdata_q & ~bit_mask));
	assign mem_raddr = (state_q == S_IDLE) ? cmd_head.addr : addr_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_q[mem_waddr] <= mem_wdata;
		end
		rdata_q <= store_q[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SWEEP;
			addr_q      <= '0;
			fill_q      <= 1'b0;
			report_q    <= 1'b0;
			wr_valid_s1 <= 1'b0;
		end else begin
			wr_valid_s1 <= (state_q == S_RMW);
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						case (cmd_head.kind)
							K_FILL: begin
								state_q  <= S_SWEEP;
								addr_q   <= '0;
								fill_q   <= cmd_head.fill;
								report_q <= 1'b1;
							end
							K_RMW: begin
								state_q <= S_RMW;
								addr_q  <= cmd_head.addr;
							end
							K_READ:  state_q <= S_READ;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_SWEEP: begin
					addr_q <= addr_q + ADDR_W'(1);
					if (addr_q == LAST_ADDR) begin
						state_q <= S_IDLE;
					end
				end
				S_RMW: begin
					addr_q <= addr_q + ADDR_W'(1);
					if (left_q == 5'd1) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: state_q <= S_IDLE;
				S_READ:  state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			left_q <= cmd_head.count;
			pat_q  <= cmd_head.pattern;
			bit_q  <= cmd_head.bit_idx;
		end else if (state_q == S_RMW) begin
			left_q <= left_q - 5'd1;
			pat_q  <= pat_q << 1;
		end
		wr_addr_s1 <= addr_q;
		wr_on_s1   <= pat_q[15];
	end

	// result queue
	assign empty     = (res_cnt_q == '0);
	assign status    = res_mem_q[res_rptr_q].status;
	assign read_data = res_mem_q[res_rptr_q].data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wptr_q <= '0;
			res_rptr_q <= '0;
			res_cnt_q  <= '0;
		end else begin
			if (res_push) begin
				res_wptr_q <= res_wptr_q + QPTR_W'(1);
			end
			if (res_pop) begin
				res_rptr_q <= res_rptr_q + QPTR_W'(1);
			end
			case ({res_push, res_pop})
				2'b10:   res_cnt_q <= res_cnt_q + QCNT_W'(1);
				2'b01:   res_cnt_q <= res_cnt_q - QCNT_W'(1);
				default: res_cnt_q <= res_cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			res_mem_q[res_wptr_q] <= res_new;
		end
	end

endmodule
`default_nettype wire

/* hdl/page_framebuffer_glyph_writer.sv */
`timescale 1ns / 1ps
`default_nettype none
// Page-layout monochrome framebuffer (1024 bytes) with cursor, pixel, fill,
// glyph-row and refresh-read requests.
// Input: a request is taken when push is high and full is low. Results leave
// in request order, one per request: the head result is on status/read_data
// while empty is low and is taken when pop is high.
// The front decodes each request in the cycle it arrives, tracks the cursor
// and queues two requests; the back runs them against the single store.
// A pixel (n = 1) or a glyph row of n columns does one store
// read-modify-write per column, pipelined one column a cycle; a fill
// writes one byte per cycle. All requests share the one store port pair,
// and the back starts a request only when it is done with the last one.
// After reset the back clears the store with full held high.
// If the receiver stops popping, the two-entry result queue fills, the back
// stops starting requests, and the input queue then raises full.
module page_framebuffer_glyph_writer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  action,
	input  logic [6:0]  pos_x,
	input  logic [6:0]  pos_y,
	input  logic        pixel_value,
	input  logic [15:0] glyph_pattern,
	input  logic [4:0]  glyph_row,
	input  logic [4:0]  start_col,
	input  logic [4:0]  glyph_width,
	input  logic        last_row,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  status,
	output logic [7:0]  read_data
);
	import pfgw_pkg::*;

	logic      cmd_valid;
	cmd_t      cmd_head;
	back_ctl_t back_ctl;

	pfgw_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.action        (action),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.pixel_value   (pixel_value),
		.glyph_pattern (glyph_pattern),
		.glyph_row     (glyph_row),
		.start_col     (start_col),
		.glyph_width   (glyph_width),
		.last_row      (last_row),
		.cmd_valid     (cmd_valid),
		.cmd_head      (cmd_head),
		.back_ctl      (back_ctl)
	);

	pfgw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_head  (cmd_head),
		.back_ctl  (back_ctl),
		.pop       (pop),
		.empty     (empty),
		.status    (status),
		.read_data (read_data)
	);

endmodule
`default_nettype wire

/* hdl/pfgw_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "page_framebuffer_glyph_writer_assert.svh"
module pfgw_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       push,
	input logic       full,
	input logic       pop,
	input logic       empty,
	input logic [1:0] status,
	input logic [7:0] read_data
);
	import pfgw_pkg::*;

	// requests taken whose results have not yet left
	logic [3:0] owed_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = push && !full;
	assign out_acc = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owed_q <= '0;
		end else begin
			owed_q <= owed_q + {3'b000, in_acc} - {3'b000, out_acc};
		end
	end

	`PFGW_ASSERT_IMP(a_result_owed, !empty, owed_q != 4'd0)
	`PFGW_ASSERT_IMP(a_status_code, !empty, status == STAT_OK || status == STAT_RANGE || status == STAT_BADCOL)
	`PFGW_ASSERT_IMP(a_error_no_data, !empty && status != STAT_OK, read_data == 8'd0)
	`PFGW_ASSERT_NXT(a_head_holds, !empty && !pop, !empty && $stable(status) && $stable(read_data))

endmodule

bind page_framebuffer_glyph_writer pfgw_checker u_pfgw_checker (.*);
`default_nettype wire
